/* rtl/core/ile_pkg.sv */
// Package for the indexed list engine: sizes, operation and status codes,
// and the control word that the top level broadcasts to the cell chain.
// No dependencies.
package ile_pkg;

   localparam int DEPTH      = 16;
   localparam int WORD_BITS  = 32;
   localparam int KIND_BITS  = 3;
   localparam int POS_BITS   = 4;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam int STAT_BITS  = 2;

   // operation codes carried in kind
   localparam logic [KIND_BITS-1:0] KIND_PUSH   = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_INSERT = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_POP    = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_REMOVE = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_READ   = 3'd4;

   // status codes
   localparam logic [STAT_BITS-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_BITS-1:0] ST_FULL   = 2'd1;
   localparam logic [STAT_BITS-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STAT_BITS-1:0] ST_BADPOS = 2'd3;

   // what the chain does this cycle
   localparam logic [1:0] MODE_HOLD   = 2'd0;
   localparam logic [1:0] MODE_PUSH   = 2'd1;
   localparam logic [1:0] MODE_INSERT = 2'd2;
   localparam logic [1:0] MODE_REMOVE = 2'd3;

   typedef struct packed {
      logic [1:0]            mode;
      logic [POS_BITS-1:0]   pos;
      logic [COUNT_BITS-1:0] count;
      logic [WORD_BITS-1:0]  word;
   } cell_ctl_type;

endpackage

/* rtl/core/ile_req_if.sv */
// Request channel of the indexed list engine: valid/ready plus one operation word.
// Depends on ile_pkg.
interface ile_req_if
   import ile_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [KIND_BITS-1:0] kind;
   logic [WORD_BITS-1:0] data_word;
   logic [POS_BITS-1:0]  position;

   modport source (output valid, kind, data_word, position, input ready);
   modport sink   (input valid, kind, data_word, position, output ready);
endinterface

/* rtl/core/ile_rsp_if.sv */
// Response channel of the indexed list engine: valid/ready plus one result word.
// Depends on ile_pkg.
interface ile_rsp_if
   import ile_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [WORD_BITS-1:0]  result_word;
   logic [COUNT_BITS-1:0] item_count;
   logic [STAT_BITS-1:0]  status;

   modport source (output valid, result_word, item_count, status, input ready);
   modport sink   (input valid, result_word, item_count, status, output ready);
endinterface

/* rtl/core/indexed_list_engine.sv */
// Indexed list engine: ordered list of up to DEPTH words in a chain of cells.
// Response: the result is registered and appears in the cycle after the request word is taken.
// Throughput: one operation per cycle while the response side drains; every cell updates in the same cycle,
// so insert and remove shift the whole list at once.
// Reset (synchronous, active high) empties the list and drops a pending result;
// stored words are not cleared, only entries below the count are ever read.
module indexed_list_engine
   import ile_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   ile_req_if.sink    req_chan,
   ile_rsp_if.source  rsp_chan
);

   // list state
   logic [COUNT_BITS-1:0] count_ff, count_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0]  result_word_ff, result_word_in;
   logic [COUNT_BITS-1:0] item_count_ff;
   logic [STAT_BITS-1:0]  status_ff, status_in;

   logic                  accept;
   logic                  full;
   logic                  empty;
   logic                  pos_ok;
   logic [1:0]            mode;
   logic [POS_BITS-1:0]   sel_idx;
   logic [COUNT_BITS-1:0] last_idx;
   cell_ctl_type          ctl;

   logic [WORD_BITS-1:0]  cell_word [DEPTH];

   // The response register frees up the same cycle it is drained, so a new
   // word is taken whenever the output side is empty or being read.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign full     = (count_ff == COUNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pos_ok   = (COUNT_BITS'(req_chan.position) < count_ff);
   assign last_idx = count_ff - 1'b1;

   // Single read port on the chain: pop reads the top entry, others the position.
   assign sel_idx = (req_chan.kind == KIND_POP) ? last_idx[POS_BITS-1:0]
                                                : req_chan.position;

   // Decode the operation into chain mode, new count and response fields.
   always_comb begin
      mode           = MODE_HOLD;
      count_in       = count_ff;
      status_in      = ST_OK;
      result_word_in = '0;
      unique case (req_chan.kind)
         KIND_PUSH: begin
            if (full) status_in = ST_FULL;
            else begin
               mode     = MODE_PUSH;
               count_in = count_ff + 1'b1;
            end
         end
         KIND_INSERT: begin
            // fullness wins over a bad position
            if (full) status_in = ST_FULL;
            else if (!pos_ok) status_in = ST_BADPOS;
            else begin
               mode     = MODE_INSERT;
               count_in = count_ff + 1'b1;
            end
         end
         KIND_POP: begin
            if (empty) status_in = ST_EMPTY;
            else begin
               count_in       = last_idx;
               result_word_in = cell_word[sel_idx];
            end
         end
         KIND_REMOVE: begin
            if (empty) status_in = ST_EMPTY;
            else if (!pos_ok) status_in = ST_BADPOS;
            else begin
               mode           = MODE_REMOVE;
               count_in       = last_idx;
               result_word_in = cell_word[sel_idx];
            end
         end
         KIND_READ: begin
            if (empty) status_in = ST_EMPTY;
            else if (!pos_ok) status_in = ST_BADPOS;
            else result_word_in = cell_word[sel_idx];
         end
         default: begin
            // unused codes leave the list alone and answer ok
            status_in = ST_OK;
         end
      endcase
   end

   // Broadcast to the cells; nothing moves unless the word is taken.
   always_comb begin
      ctl.mode  = accept ? mode : MODE_HOLD;
      ctl.pos   = req_chan.position;
      ctl.count = count_ff;
      ctl.word  = req_chan.data_word;
   end

   // Cell chain: each cell sees its lower and upper neighbor; ends see zero.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [WORD_BITS-1:0] lower_w;
      logic [WORD_BITS-1:0] upper_w;

      if (g == 0) begin : g_lo_end
         assign lower_w = '0;
      end else begin : g_lo
         assign lower_w = cell_word[g-1];
      end

      if (g == DEPTH - 1) begin : g_hi_end
         assign upper_w = '0;
      end else begin : g_hi
         assign upper_w = cell_word[g+1];
      end

      ile_cell u_cell (
         .clock      (clock),
         .cell_idx   (POS_BITS'(g)),
         .ctl        (ctl),
         .lower_word (lower_w),
         .upper_word (upper_w),
         .entry_word (cell_word[g])
      );
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) count_ff <= count_in;
      end
   end

   // response payload, loaded only with a newly taken word
   always_ff @(posedge clock) begin
      if (accept) begin
         result_word_ff <= result_word_in;
         item_count_ff  <= count_in;
         status_ff      <= status_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.result_word = result_word_ff;
   assign rsp_chan.item_count  = item_count_ff;
   assign rsp_chan.status      = status_ff;

endmodule

/* rtl/core/ile_cell.sv */
// One list slot: holds an entry and loads it from the new word or a neighbor.
// Depends on ile_pkg.
module ile_cell
   import ile_pkg::*;
(
   input  logic                 clock,
   input  logic [POS_BITS-1:0]  cell_idx,
   input  cell_ctl_type         ctl,
   input  logic [WORD_BITS-1:0] lower_word,
   input  logic [WORD_BITS-1:0] upper_word,
   output logic [WORD_BITS-1:0] entry_word
);

   logic [WORD_BITS-1:0]  entry_ff;
   logic [WORD_BITS-1:0]  entry_in;
   logic [COUNT_BITS-1:0] idx_ext;

   assign idx_ext = COUNT_BITS'(cell_idx);

   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.mode)
         MODE_PUSH: begin
            if (idx_ext == ctl.count) entry_in = ctl.word;
         end
         MODE_INSERT: begin
            if (cell_idx == ctl.pos) entry_in = ctl.word;
            else if (cell_idx > ctl.pos && idx_ext <= ctl.count) entry_in = lower_word;
         end
         MODE_REMOVE: begin
            if (cell_idx >= ctl.pos && (idx_ext + 1'b1) < ctl.count) entry_in = upper_word;
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_word = entry_ff;

endmodule

/* sim/indexed_list_engine_test.sv */
// Self-checking bench for indexed_list_engine: random and directed list operations,
// predicted by a mirror of the list and checked word by word on the reply channel.
// Depends on ile_pkg, ile_req_if, ile_rsp_if and the engine RTL.
module indexed_list_engine_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ile_pkg::*;

   // cycles with no word moving on either channel before the run is abandoned
   localparam int STALL_LIMIT = 1000;
   // cycles to let pass after the last reply, the engine answers in the cycle after a request is taken
   localparam int DRAIN_CYCLES = 4;

   // range of kind codes the engine ignores
   localparam logic [KIND_BITS-1:0] KIND_SPARE_LO = 3'd5;
   localparam logic [KIND_BITS-1:0] KIND_SPARE_HI = 3'd7;

   // which way the random phases push the list
   typedef enum {LEAN_GROW, LEAN_SHRINK, LEAN_EVEN} lean_type;

   // one predicted reply, the op is kept for messages only
   typedef struct packed {
      logic [KIND_BITS-1:0]  op;
      logic [WORD_BITS-1:0]  word;
      logic [COUNT_BITS-1:0] count;
      logic [STAT_BITS-1:0]  status;
   } reply_type;

   // Mirror of the list contents plus the replies it still owes.
   class list_mirror;
      logic [WORD_BITS-1:0] slots [DEPTH];
      int                   fill;
      reply_type            pending [$];
      int                   mismatches;

      function new();
         foreach (slots[i]) slots[i] = '0;
         fill       = 0;
         mismatches = 0;
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= 10) $display("%s", what);
      endfunction

      // note an accepted request word and queue the reply it must produce
      function void apply_op(logic [KIND_BITS-1:0] op, logic [WORD_BITS-1:0] word,
                             logic [POS_BITS-1:0] pos);
         logic [WORD_BITS-1:0] res;
         logic [STAT_BITS-1:0] st;
         int                   at;
         int                   i;
         res = '0;
         st  = ST_OK;
         at  = int'(pos);
         case (op)
            KIND_PUSH: begin
               if (fill >= DEPTH) st = ST_FULL;
               else begin
                  slots[fill] = word;
                  fill++;
               end
            end
            KIND_INSERT: begin
               // fullness wins over a bad position
               if (fill >= DEPTH) st = ST_FULL;
               else if (at >= fill) st = ST_BADPOS;
               else begin
                  for (i = fill; i > at; i--) slots[i] = slots[i-1];
                  slots[at] = word;
                  fill++;
               end
            end
            KIND_POP: begin
               if (fill == 0) st = ST_EMPTY;
               else begin
                  fill--;
                  res = slots[fill];
               end
            end
            KIND_REMOVE: begin
               if (fill == 0) st = ST_EMPTY;
               else if (at >= fill) st = ST_BADPOS;
               else begin
                  res = slots[at];
                  for (i = at; i + 1 < fill; i++) slots[i] = slots[i+1];
                  fill--;
               end
            end
            KIND_READ: begin
               if (fill == 0) st = ST_EMPTY;
               else if (at >= fill) st = ST_BADPOS;
               else res = slots[at];
            end
            default: ;  // unused kinds leave the list alone and report ok
         endcase
         pending.push_back(reply_type'{op, res, COUNT_BITS'(fill), st});
      endfunction

      // compare one accepted reply word with the oldest prediction
      function void check_reply(logic [WORD_BITS-1:0] word, logic [COUNT_BITS-1:0] count,
                                logic [STAT_BITS-1:0] status);
         reply_type want;
         if (pending.size() == 0) begin
            flag($sformatf("unexpected reply: word %h count %0d status %0d",
                           word, count, status));
            return;
         end
         want = pending.pop_front();
         if (word !== want.word || count !== want.count || status !== want.status)
            flag($sformatf({"reply mismatch (op %0d): expected word %h count %0d status %0d,",
                            " got word %h count %0d status %0d"},
                           want.op, want.word, want.count, want.status,
                           word, count, status));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   ile_req_if req_chan ();
   ile_rsp_if rsp_chan ();

   indexed_list_engine dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #10 clock = ~clock;

   list_mirror mirror = new();

   // when set, neither side inserts idle cycles
   bit quiet = 1'b0;
   int idle_cycles = 0;

   function automatic int draw_wait();
      return quiet ? 0 : $urandom_range(0, 8);
   endfunction

   // Monitor: replies are checked before a request taken on the same edge is
   // noted; as replies are registered, a reply never belongs to that request.
   // The watchdog counts edges at which no word moved.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
            mirror.check_reply(rsp_chan.result_word, rsp_chan.item_count, rsp_chan.status);
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1)
            mirror.apply_op(req_chan.kind, req_chan.data_word, req_chan.position);
      end
      if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Reply side: hold ready low for a random stall before each reply word,
   // then keep it high until a word is taken.
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock);
         while (reset || !(rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1));
         @(negedge clock);
      end
   end

   // Request side: called on a falling edge, returns on the falling edge after
   // the word was taken. valid is only lowered when a gap is drawn.
   task automatic send_op(input logic [KIND_BITS-1:0] op, input logic [WORD_BITS-1:0] word,
                          input logic [POS_BITS-1:0] pos);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.kind      <= op;
      req_chan.data_word <= word;
      req_chan.position  <= pos;
      req_chan.valid     <= 1'b1;
      do @(posedge clock);
      while (req_chan.ready !== 1'b1);
      @(negedge clock);
   endtask

   function automatic logic [KIND_BITS-1:0] pick_kind(lean_type lean);
      int r;
      int t_push, t_ins, t_pop, t_rem, t_read;
      r = $urandom_range(0, 99);
      case (lean)
         LEAN_GROW:   begin t_push = 35; t_ins = 65; t_pop = 75; t_rem = 85; t_read = 95; end
         LEAN_SHRINK: begin t_push = 10; t_ins = 20; t_pop = 50; t_rem = 80; t_read = 95; end
         default:     begin t_push = 22; t_ins = 44; t_pop = 60; t_rem = 76; t_read = 94; end
      endcase
      if (r < t_push) return KIND_PUSH;
      if (r < t_ins)  return KIND_INSERT;
      if (r < t_pop)  return KIND_POP;
      if (r < t_rem)  return KIND_REMOVE;
      if (r < t_read) return KIND_READ;
      // unused kinds, noise
      return KIND_BITS'($urandom_range(int'(KIND_SPARE_LO), int'(KIND_SPARE_HI)));
   endfunction

   // mostly a live position, now and then anything the field can hold
   function automatic logic [POS_BITS-1:0] pick_position();
      if (mirror.fill > 0 && $urandom_range(0, 9) < 8)
         return POS_BITS'($urandom_range(0, mirror.fill - 1));
      return POS_BITS'($urandom_range(0, DEPTH - 1));
   endfunction

   function automatic logic [WORD_BITS-1:0] pick_word();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return WORD_BITS'($urandom);
   endfunction

   initial begin
      int       i;
      int       p;
      lean_type lean;

      req_chan.valid     = 1'b0;
      req_chan.kind      = KIND_PUSH;
      req_chan.data_word = '0;
      req_chan.position  = '0;

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // --- directed: empty list, unused kind, edges of the fields ---
      send_op(KIND_POP,    '0, '0);
      send_op(KIND_REMOVE, '0, POS_BITS'(DEPTH - 1));
      send_op(KIND_READ,   '0, '0);
      send_op(KIND_INSERT, 32'h1234_5678, '0);   // empty: position never below count
      send_op(KIND_SPARE_HI, '1, '1);            // ignored
      send_op(KIND_PUSH,   '1, '0);
      send_op(KIND_INSERT, '0, '0);
      send_op(KIND_READ,   '0, POS_BITS'(DEPTH - 1));  // past the end
      send_op(KIND_REMOVE, '0, 4'd1);            // last entry by position
      // fill to capacity, then hit it
      for (i = 1; i < DEPTH; i++) send_op(KIND_PUSH, pick_word(), '0);
      send_op(KIND_PUSH,   32'hDEAD_BEEF, '0);
      send_op(KIND_INSERT, 32'hDEAD_BEEF, POS_BITS'(DEPTH - 1));
      send_op(KIND_READ,   '0, POS_BITS'(DEPTH - 1));
      send_op(KIND_REMOVE, '0, '0);
      send_op(KIND_POP,    '0, '0);

      // --- random phases, each with a random lean (grow, shrink or even), some with no idling ---
      for (p = 0; p < 30; p++) begin
         lean  = lean_type'($urandom_range(0, 2));
         quiet = ($urandom_range(0, 3) == 0);
         for (i = 0; i < 31; i++) send_op(pick_kind(lean), pick_word(), pick_position());
      end
      quiet = 1'b0;
      req_chan.valid <= 1'b0;

      // drain, then wait out DRAIN_CYCLES to catch stray replies
      while (mirror.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mirror.mismatches == 0 && mirror.pending.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
